// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the HSL to RGB block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication check.
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// Next-cycle implication check.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== rtl/hsl2rgb_pkg.sv =====
// Types, constants and helper functions of the HSL to RGB converter.
package hsl2rgb_pkg;

   // Fixed point format: FRAC_BITS fraction bits, ONE_I means 1.0.
   localparam int FRAC_BITS     = 16;
   localparam int ONE_I         = 1 << FRAC_BITS;
   localparam int HALF_I        = ONE_I / 2;
   localparam int SIXTH_I       = (2 * ONE_I + 6) / 12;
   localparam int THIRD_I       = (2 * ONE_I + 3) / 6;
   localparam int TWO_THIRDS_I  = (4 * ONE_I + 3) / 6;

   // Field and datapath widths.
   localparam int IN_W    = 20;
   localparam int CHAN_W  = 17;
   localparam int UNIT_W  = FRAC_BITS + 1;
   localparam int RAMP_W  = $clog2(SIXTH_I + 2);
   localparam int VAL_W   = UNIT_W + 2;
   localparam int DIFF_W  = UNIT_W + 1;
   localparam int D6_W    = DIFF_W + 3;
   localparam int PRD_W   = D6_W + RAMP_W + 1;
   localparam int RP_W    = PRD_W - FRAC_BITS;
   localparam int SUM_W   = RP_W + 2;

   typedef logic signed [IN_W-1:0]   in_type;
   typedef logic [CHAN_W-1:0]        chan_type;
   typedef logic [UNIT_W-1:0]        unit_type;
   typedef logic [RAMP_W-1:0]        ramp_type;
   typedef logic signed [VAL_W-1:0]  val_type;
   typedef logic [DIFF_W-1:0]        diff_type;
   typedef logic [D6_W-1:0]          d6_type;
   typedef logic [RP_W-1:0]          rp_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   // Segment of the piecewise hue ramp.
   typedef enum logic [1:0] {
      RGN_RISE,
      RGN_HIGH,
      RGN_FALL,
      RGN_LOW
   } region_type;

   typedef struct packed {
      region_type region;
      ramp_type   factor;
   } seg_type;

   // Clamp a signed input field to 0..ONE.
   function automatic unit_type clamp_unit(in_type v);
      unit_type r;
      if (v < 0) begin
         r = '0;
      end else if (v > in_type'(ONE_I)) begin
         r = unit_type'(ONE_I);
      end else begin
         r = v[UNIT_W-1:0];
      end
      return r;
   endfunction

   // Find the ramp segment of a wrapped hue and its slope factor.
   function automatic seg_type classify(unit_type t);
      seg_type seg;
      if (t < unit_type'(SIXTH_I)) begin
         seg.region = RGN_RISE;
         seg.factor = t[RAMP_W-1:0];
      end else if (t < unit_type'(HALF_I)) begin
         seg.region = RGN_HIGH;
         seg.factor = '0;
      end else if (t < unit_type'(TWO_THIRDS_I)) begin
         seg.region = RGN_FALL;
         seg.factor = RAMP_W'(unit_type'(TWO_THIRDS_I) - t);
      end else begin
         seg.region = RGN_LOW;
         seg.factor = '0;
      end
      return seg;
   endfunction

endpackage

// ===== rtl/hsl2rgb_req_if.sv =====
// Input channel: one HSL word per handshake.
interface hsl2rgb_req_if import hsl2rgb_pkg::*;;
   logic   valid;
   logic   ready;
   in_type hue;
   in_type saturation;
   in_type lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

// ===== rtl/hsl2rgb_rsp_if.sv =====
// Result channel: one RGB word per handshake.
interface hsl2rgb_rsp_if import hsl2rgb_pkg::*;;
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/hsl_to_rgb_fixed_unit.sv =====
// HSL to RGB converter, fixed point with 16 fraction bits (65536 is 1.0). Hue wraps
// modulo one turn, saturation and lightness clamp to 0..1, and each RGB channel is
// the standard hue ramp saturated to 0..1. The datapath is a five-stage pipeline:
// input clamp, lightness times saturation, q/p and slope, three ramp multiplies,
// and the output register. Every stage loads in every cycle that the stage after it
// can move, so one word per cycle is sustained while the result channel is ready.
// Each stage has its own valid bit and load enable, so a stalled result only holds
// the full stages behind it and bubbles are squeezed out while the output waits.
`include "assert_macros.svh"

module hsl_to_rgb_fixed_unit import hsl2rgb_pkg::*; (
   input logic            clock,
   input logic            reset,
   hsl2rgb_req_if.sink    req_ch,
   hsl2rgb_rsp_if.source  rsp_ch
);

   // Stage valid bits and load enables.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !v5_ff || rsp_ch.ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ch.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_ch.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // Stage 1: wrap the hue and clamp saturation and lightness.
   logic [FRAC_BITS-1:0] h1_ff;
   unit_type             s1_ff, l1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         h1_ff <= req_ch.hue[FRAC_BITS-1:0];
         s1_ff <= clamp_unit(req_ch.saturation);
         l1_ff <= clamp_unit(req_ch.lightness);
      end
   end

   // Stage 2: rounded lightness times saturation, channel hue offsets.
   logic [2*UNIT_W-1:0]     ls_prod;
   logic [2*UNIT_W:0]       ls_rnd;
   logic [FRAC_BITS+1:0]    tr_sum;
   logic signed [FRAC_BITS+1:0] tb_diff;
   unit_type                tr_in, tb_in;
   unit_type                rls2_ff, s2_ff, l2_ff;
   seg_type                 seg_r2_ff, seg_g2_ff, seg_b2_ff;

   always_comb begin
      ls_prod = l1_ff * s1_ff;
      ls_rnd  = {1'b0, ls_prod} + (2*UNIT_W+1)'(HALF_I);
      tr_sum  = {2'b00, h1_ff} + (FRAC_BITS+2)'(THIRD_I);
      tr_in   = (tr_sum > (FRAC_BITS+2)'(ONE_I)) ?
                UNIT_W'(tr_sum - (FRAC_BITS+2)'(ONE_I)) : UNIT_W'(tr_sum);
      tb_diff = $signed({2'b00, h1_ff}) - $signed((FRAC_BITS+2)'(THIRD_I));
      tb_in   = (tb_diff < 0) ? UNIT_W'(tb_diff + $signed((FRAC_BITS+2)'(ONE_I)))
                              : UNIT_W'(tb_diff);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         rls2_ff   <= ls_rnd[FRAC_BITS +: UNIT_W];
         s2_ff     <= s1_ff;
         l2_ff     <= l1_ff;
         seg_r2_ff <= classify(tr_in);
         seg_g2_ff <= classify(UNIT_W'(h1_ff));
         seg_b2_ff <= classify(tb_in);
      end
   end

   // Stage 3: q and p from the lightness split, six times their difference.
   val_type  l_v, q_in, p_in, diff_v;
   diff_type d_in;
   val_type  q3_ff, p3_ff;
   d6_type   d6_3_ff;
   seg_type  seg_r3_ff, seg_g3_ff, seg_b3_ff;

   always_comb begin
      l_v    = val_type'(l2_ff);
      q_in   = (l2_ff <= unit_type'(HALF_I)) ? l_v + val_type'(rls2_ff)
                                            : l_v + val_type'(s2_ff) - val_type'(rls2_ff);
      p_in   = (l_v <<< 1) - q_in;
      diff_v = q_in - p_in;
      d_in   = (q_in > p_in) ? diff_v[DIFF_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         q3_ff     <= q_in;
         p3_ff     <= p_in;
         d6_3_ff   <= (D6_W'(d_in) << 2) + (D6_W'(d_in) << 1);
         seg_r3_ff <= seg_r2_ff;
         seg_g3_ff <= seg_g2_ff;
         seg_b3_ff <= seg_b2_ff;
      end
   end

   // Stage 4: rounded ramp products, one multiplier per channel.
   logic [PRD_W-1:0] prd_r, prd_g, prd_b;
   rp_type           rp_r4_ff, rp_g4_ff, rp_b4_ff;
   val_type          q4_ff, p4_ff;
   region_type       rg_r4_ff, rg_g4_ff, rg_b4_ff;

   always_comb begin
      prd_r = PRD_W'(d6_3_ff) * PRD_W'(seg_r3_ff.factor) + PRD_W'(HALF_I);
      prd_g = PRD_W'(d6_3_ff) * PRD_W'(seg_g3_ff.factor) + PRD_W'(HALF_I);
      prd_b = PRD_W'(d6_3_ff) * PRD_W'(seg_b3_ff.factor) + PRD_W'(HALF_I);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rp_r4_ff <= prd_r[FRAC_BITS +: RP_W];
         rp_g4_ff <= prd_g[FRAC_BITS +: RP_W];
         rp_b4_ff <= prd_b[FRAC_BITS +: RP_W];
         q4_ff    <= q3_ff;
         p4_ff    <= p3_ff;
         rg_r4_ff <= seg_r3_ff.region;
         rg_g4_ff <= seg_g3_ff.region;
         rg_b4_ff <= seg_b3_ff.region;
      end
   end

   // Stage 5: pick the segment value and saturate to 0..1.
   function automatic chan_type pick(region_type rg, val_type q, val_type p, rp_type rp);
      sum_type base;
      sum_type add;
      sum_type v;
      chan_type r;
      base = (rg == RGN_HIGH) ? SUM_W'(q) : SUM_W'(p);
      add  = (rg == RGN_RISE || rg == RGN_FALL) ? sum_type'(rp) : '0;
      v    = base + add;
      if (v < 0) begin
         r = '0;
      end else if (v > sum_type'(ONE_I)) begin
         r = chan_type'(ONE_I);
      end else begin
         r = v[CHAN_W-1:0];
      end
      return r;
   endfunction

   chan_type red5_ff, green5_ff, blue5_ff;

   always_ff @(posedge clock) begin
      if (en5) begin
         red5_ff   <= pick(rg_r4_ff, q4_ff, p4_ff, rp_r4_ff);
         green5_ff <= pick(rg_g4_ff, q4_ff, p4_ff, rp_g4_ff);
         blue5_ff  <= pick(rg_b4_ff, q4_ff, p4_ff, rp_b4_ff);
      end
   end

   assign rsp_ch.valid = v5_ff;
   assign rsp_ch.red   = red5_ff;
   assign rsp_ch.green = green5_ff;
   assign rsp_ch.blue  = blue5_ff;

   // Checks on the pipeline and the datapath.
   `ASSERT_IMPLY(a_q_not_below_p, clock, reset, v3_ff, q3_ff >= p3_ff, "q fell below p")
   `ASSERT_IMPLY(a_full_stall_blocks, clock, reset,
      v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && !rsp_ch.ready, !req_ch.ready,
      "input taken while every stage is full and stalled")
   `ASSERT_NEXT(a_accept_fills_stage1, clock, reset, req_ch.valid && req_ch.ready, v1_ff,
      "accepted word did not reach the first stage")
   `ASSERT_IMPLY(a_channel_range, clock, reset, v5_ff,
      red5_ff <= chan_type'(ONE_I) && green5_ff <= chan_type'(ONE_I) &&
      blue5_ff <= chan_type'(ONE_I), "channel value above full scale")

endmodule
